// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

    localparam int unsigned HEADER_BYTES = 24;
    localparam int unsigned ALIGN_LOG2   = 4;
    localparam int unsigned ALIGN_BYTES  = 1 << ALIGN_LOG2;

    localparam logic [31:0] RESET_BASE  = 32'h0020_0000;
    localparam logic [24:0] RESET_BYTES = 25'h080_0000;

    typedef struct packed {
        logic [24:0] off;
        logic [24:0] size;
        logic        free;
    } t_entry;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_BADPTR  = 3'd3,
        ST_DBLFREE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_REINIT  = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    localparam logic [0:0] CFG_BASE  = 1'b0;
    localparam logic [0:0] CFG_BYTES = 1'b1;

endpackage

// ===== rtl/ffha_tbl.sv =====
module ffha_tbl #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_wa,
    input  ffha_pkg::t_entry               i_wd,
    input  logic                           i_re,
    input  logic [$clog2(DEPTH)-1:0]       i_ra,
    output ffha_pkg::t_entry               o_rd
);
    import ffha_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Channel   | valid    | stall    | payload
// request   | i_valid  | o_stall  | i_func, i_req_size, i_release_addr
// result    | o_valid  | i_stall  | o_result_addr, o_status, o_used_bytes, o_free_bytes
// config    | i_cfg_we | -        | i_cfg_idx, i_cfg_data
//
// One request at a time: a pipelined first-fit scan of the block table (one entry a
// cycle through the single table RAM) up to the chosen entry, then a shift of the entries
// behind it on split or merge, then the table writes in S_WR1 and S_WR2, and the result
// beat loaded in S_DONE.
// Reset is synchronous; the S_INIT state after reset writes the initial free block.
// A pending result does not block a new request; finishing waits for the result slot.
module first_fit_heap_allocator_unit #(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [23:0] i_req_size,
    input  logic [31:0] i_release_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_addr,
    output logic [2:0]  o_status,
    output logic [24:0] o_used_bytes,
    output logic [24:0] o_free_bytes
);
    import ffha_pkg::*;

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_NEXT  = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_WR1   = 8'b0010_0000,
        S_WR2   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state       r_state;
    logic         r_from_rst;
    logic [31:0]  r_base;
    logic [24:0]  r_heap;
    logic [CW-1:0] r_count;
    logic [24:0]  r_total;
    logic         r_alloc;
    logic [24:0]  r_need;
    logic [31:0]  r_raddr;
    logic [CW-1:0] r_idx;
    logic         r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    t_entry       r_prev;
    t_entry       r_cur;
    t_entry       r_pv;
    logic         r_pvf;
    logic [IW-1:0] r_hi;
    logic         r_up;
    logic [1:0]   r_k;
    logic [IW-1:0] r_src;
    logic [CW-1:0] r_left;
    logic         r_w1v;
    logic [IW-1:0] r_w1a;
    t_entry       r_w1d;
    logic         r_w2v;
    logic [IW-1:0] r_w2a;
    t_entry       r_w2d;
    logic [31:0]  r_addr;
    t_status      r_st;
    logic         r_ov;
    logic [31:0]  r_o_addr;
    logic [2:0]   r_o_st;
    logic [24:0]  r_o_used;
    logic [24:0]  r_o_free;

    logic         we;
    logic [IW-1:0] wa;
    t_entry       wd;
    logic         re;
    logic [IW-1:0] ra;
    t_entry       rd;

    ffha_tbl #(.DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk (i_clk),
        .i_we  (we),
        .i_wa  (wa),
        .i_wd  (wd),
        .i_re  (re),
        .i_ra  (ra),
        .o_rd  (rd)
    );

    logic          accept;
    logic          out_free;
    logic [24:0]   req_need;
    logic [31:0]   rd_ptr;
    logic          hit;
    logic [CW-1:0] hi_c;
    logic          split;
    logic [24:0]   init_heap;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign req_need = ({1'b0, i_req_size} + 25'(ALIGN_BYTES - 1))
                      & ~25'(ALIGN_BYTES - 1);
    assign rd_ptr   = r_base + 32'(rd.off) + 32'(HEADER_BYTES);
    assign hit      = r_alloc ? (rd.free && rd.size >= r_need) : (rd_ptr == r_raddr);
    assign hi_c     = CW'(r_hi);
    assign split    = (r_count < CW'(MAX_BLOCKS)) &&
                      ({2'b0, r_cur.size} >=
                       {2'b0, r_need} + 27'(2 * HEADER_BYTES + ALIGN_BYTES));
    assign init_heap = r_from_rst ? RESET_BYTES : r_heap;

    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = r_w1d;
        re = 1'b0;
        ra = '0;
        case (r_state)
            S_INIT: begin
                we = 1'b1;
                wd.off  = '0;
                wd.size = (init_heap > 25'(HEADER_BYTES)) ?
                          init_heap - 25'(HEADER_BYTES) : '0;
                wd.free = 1'b1;
            end
            S_SCAN: begin
                re = r_idx < r_count;
                ra = r_idx[IW-1:0];
            end
            S_SHIFT: begin
                re = r_left != '0;
                ra = r_src;
                we = r_rd_vld;
                wa = r_up ? r_rd_idx + IW'(1) : r_rd_idx - IW'(r_k);
                wd = rd;
            end
            S_WR1: begin
                we = r_w1v;
                wa = r_w1a;
                wd = r_w1d;
            end
            S_WR2: begin
                we = r_w2v;
                wa = r_w2a;
                wd = r_w2d;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= ra;
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_from_rst <= 1'b1;
            r_base     <= RESET_BASE;
            r_heap     <= RESET_BYTES;
            r_count    <= CW'(1);
            r_total    <= '0;
            r_ov       <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= re;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:  r_base <= i_cfg_data;
                    CFG_BYTES: r_heap <= i_cfg_data[24:0];
                    default: begin
                    end
                endcase
            end
            if (o_valid && !i_stall && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_count <= CW'(1);
                    r_total <= '0;
                    r_addr  <= '0;
                    r_st    <= ST_OK;
                    r_state <= r_from_rst ? S_IDLE : S_DONE;
                    r_from_rst <= 1'b0;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_alloc <= i_func == FN_ALLOC;
                        r_need  <= req_need;
                        r_raddr <= i_release_addr;
                        r_idx   <= '0;
                        r_addr  <= '0;
                        r_st    <= ST_OK;
                        r_w1v   <= 1'b0;
                        r_w2v   <= 1'b0;
                        r_left  <= '0;
                        case (t_func'(i_func))
                            FN_ALLOC: begin
                                if (i_req_size == '0) begin
                                    r_st    <= ST_ZERO;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            FN_RELEASE: r_state <= (i_release_addr == '0) ? S_DONE : S_SCAN;
                            FN_REINIT:  r_state <= S_INIT;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (re) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rd_vld) begin
                        r_prev <= rd;
                        if (hit) begin
                            r_cur   <= rd;
                            r_hi    <= r_rd_idx;
                            r_pv    <= r_prev;
                            r_pvf   <= (r_rd_idx != '0) && r_prev.free;
                            r_state <= S_NEXT;
                        end else if (CW'(r_rd_idx) == r_count - CW'(1)) begin
                            r_st    <= r_alloc ? ST_OOM : ST_BADPTR;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_NEXT: begin
                    r_state <= S_SHIFT;
                    if (r_alloc) begin
                        r_addr <= r_base + 32'(r_cur.off) + 32'(HEADER_BYTES);
                        r_w1v  <= 1'b1;
                        if (split) begin
                            r_up    <= 1'b1;
                            r_src   <= IW'(r_count - CW'(1));
                            r_left  <= r_count - hi_c - CW'(1);
                            r_w1a   <= r_hi + IW'(1);
                            r_w1d   <= '{off:  r_cur.off + 25'(HEADER_BYTES) + r_need,
                                         size: r_cur.size - r_need - 25'(HEADER_BYTES),
                                         free: 1'b1};
                            r_w2v   <= 1'b1;
                            r_w2a   <= r_hi;
                            r_w2d   <= '{off: r_cur.off, size: r_need, free: 1'b0};
                            r_count <= r_count + CW'(1);
                            r_total <= r_total + r_need;
                        end else begin
                            r_w1a   <= r_hi;
                            r_w1d   <= '{off: r_cur.off, size: r_cur.size, free: 1'b0};
                            r_total <= r_total + r_cur.size;
                        end
                    end else if (r_cur.free) begin
                        r_st    <= ST_DBLFREE;
                        r_state <= S_DONE;
                    end else begin
                        r_total <= (r_total >= r_cur.size) ? r_total - r_cur.size : '0;
                        r_up    <= 1'b0;
                        r_w1v   <= 1'b1;
                        if (r_pvf && r_rd_vld && rd.free) begin
                            r_w1a   <= r_hi - IW'(1);
                            r_w1d   <= '{off:  r_pv.off,
                                         size: r_pv.size + r_cur.size + rd.size
                                               + 25'(2 * HEADER_BYTES),
                                         free: 1'b1};
                            r_k     <= 2'd2;
                            r_src   <= r_hi + IW'(2);
                            r_left  <= r_count - hi_c - CW'(2);
                            r_count <= r_count - CW'(2);
                        end else if (r_pvf) begin
                            r_w1a   <= r_hi - IW'(1);
                            r_w1d   <= '{off:  r_pv.off,
                                         size: r_pv.size + r_cur.size + 25'(HEADER_BYTES),
                                         free: 1'b1};
                            r_k     <= 2'd1;
                            r_src   <= r_hi + IW'(1);
                            r_left  <= r_count - hi_c - CW'(1);
                            r_count <= r_count - CW'(1);
                        end else if (r_rd_vld && rd.free) begin
                            r_w1a   <= r_hi;
                            r_w1d   <= '{off:  r_cur.off,
                                         size: r_cur.size + rd.size + 25'(HEADER_BYTES),
                                         free: 1'b1};
                            r_k     <= 2'd1;
                            r_src   <= r_hi + IW'(2);
                            r_left  <= r_count - hi_c - CW'(2);
                            r_count <= r_count - CW'(1);
                        end else begin
                            r_w1a   <= r_hi;
                            r_w1d   <= '{off: r_cur.off, size: r_cur.size, free: 1'b1};
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_left != '0) begin
                        r_left <= r_left - CW'(1);
                        r_src  <= r_up ? r_src - IW'(1) : r_src + IW'(1);
                    end else if (!r_rd_vld) begin
                        r_state <= S_WR1;
                    end
                end
                S_WR1: r_state <= S_WR2;
                S_WR2: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_addr <= r_addr;
                        r_o_st   <= r_st;
                        r_o_used <= r_total;
                        r_o_free <= (r_heap >= r_total) ? r_heap - r_total : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = r_state != S_IDLE;
    assign o_valid       = r_ov;
    assign o_result_addr = r_o_addr;
    assign o_status      = r_o_st;
    assign o_used_bytes  = r_o_used;
    assign o_free_bytes  = r_o_free;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_no_wr_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> !(r_state == S_IDLE || r_state == S_SCAN || r_state == S_DONE))
        else $error("table write outside update phase");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("request accepted but block not busy");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> o_valid)
        else $error("result not presented");

endmodule
